>>> design/mpfb_pkg.sv
// Package for the monochrome page frame store block.
// Holds panel geometry, store sizing, request codes, sequencer states and the
// store access struct. No dependencies.
`timescale 1ns / 1ps

package mpfb_pkg;

  localparam int PANEL_WIDTH  = 128;
  localparam int PANEL_HEIGHT = 64;
  localparam int PAGE_ROWS    = 8;
  localparam int PAGE_COUNT   = (PANEL_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int STORE_DEPTH  = PANEL_WIDTH * PAGE_COUNT;

  localparam int COL_W  = (PANEL_WIDTH > 1) ? $clog2(PANEL_WIDTH) : 1;
  localparam int ROW_W  = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;
  localparam int PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int ADDR_W = $clog2(STORE_DEPTH);

  // Request type codes.
  localparam logic [1:0] REQ_SET   = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_HSPAN = 2'd2;
  localparam logic [1:0] REQ_VSPAN = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_RESP
  } seq_state_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

endpackage

>>> design/mpfb_store.sv
// Page store memory: one byte per column per page, one port.
// Read data is registered. Depends on mpfb_pkg.
`timescale 1ns / 1ps

module mpfb_store
  import mpfb_pkg::*;
(
  input  logic       clk_i,
  input  mem_req_t   req_i,
  output logic [7:0] rdata_o
);

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.addr];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/mpfb_seq.sv
// Sequencer and read-modify-write unit for the page store.
// Clears the store after reset, then walks spans one byte at a time.
// Depends on mpfb_pkg.
`timescale 1ns / 1ps

module mpfb_seq
  import mpfb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] x_start_i,
  input  logic [7:0] x_end_i,
  input  logic [7:0] y_start_i,
  input  logic [7:0] y_end_i,
  input  logic       color_i,
  output logic       result_valid_o,
  output logic       pixel_value_o,
  output logic       rejected_o,
  output mem_req_t   mem_req_o,
  input  logic [7:0] mem_rdata_i
);

  seq_state_e state_q, state_d;

  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [PAGE_W-1:0] page_q, page_d;
  logic [COL_W-1:0]  xe_q, xe_d;
  logic [ROW_W-1:0]  ys_q, ys_d;
  logic [ROW_W-1:0]  ye_q, ye_d;
  logic [1:0]        type_q, type_d;
  logic              color_q, color_d;
  logic              pix_q, pix_d;
  logic              rej_q, rej_d;

  logic              accept;
  logic              reject;
  logic [COL_W-1:0]  xe_clip;
  logic [ROW_W-1:0]  ye_clip;
  logic              span_empty;
  logic              last_step;
  logic              clr_last;
  logic [7:0]        mask;
  logic [7:0]        wbyte;
  logic [ADDR_W-1:0] addr;

  assign accept = start_i && (state_q == ST_IDLE);
  assign reject = ({1'b0, x_start_i} >= 9'(PANEL_WIDTH)) ||
                  ({1'b0, y_start_i} >= 9'(PANEL_HEIGHT));

  // Clip the span ends to the last column or row of the panel.
  assign xe_clip = ({1'b0, x_end_i} >= 9'(PANEL_WIDTH)) ?
                   COL_W'(PANEL_WIDTH - 1) : COL_W'(x_end_i);
  assign ye_clip = ({1'b0, y_end_i} >= 9'(PANEL_HEIGHT)) ?
                   ROW_W'(PANEL_HEIGHT - 1) : ROW_W'(y_end_i);

  always_comb begin
    span_empty = 1'b0;
    if (req_type_i == REQ_HSPAN) begin
      span_empty = {1'b0, xe_clip} < {1'b0, COL_W'(x_start_i)};
    end else if (req_type_i == REQ_VSPAN) begin
      span_empty = {1'b0, ye_clip} < {1'b0, ROW_W'(y_start_i)};
    end
  end

  always_comb begin
    last_step = 1'b1;
    if (type_q == REQ_HSPAN) begin
      last_step = (col_q == xe_q);
    end else if (type_q == REQ_VSPAN) begin
      last_step = (page_q == PAGE_W'(ye_q >> 3));
    end
  end

  assign clr_last = (clr_q == ADDR_W'(STORE_DEPTH - 1));

  // A vertical span covers every row of the current page inside the span;
  // other requests touch a single bit.
  always_comb begin
    logic [8:0] row;
    row  = 9'd0;
    mask = 8'h00;
    if (type_q == REQ_VSPAN) begin
      for (int b = 0; b < PAGE_ROWS; b++) begin
        row = 9'(page_q) * 9'(PAGE_ROWS) + 9'(b);
        mask[b] = (row >= 9'(ys_q)) && (row <= 9'(ye_q));
      end
    end else begin
      mask = 8'h01 << ys_q[2:0];
    end
  end

  assign wbyte = color_q ? (mem_rdata_i | mask) : (mem_rdata_i & ~mask);
  assign addr  = ADDR_W'(ADDR_W'(page_q) * ADDR_W'(PANEL_WIDTH) + ADDR_W'(col_q));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          state_d = (reject || span_empty) ? ST_RESP : ST_READ;
        end
      end
      ST_READ:  state_d = ST_WRITE;
      ST_WRITE: state_d = last_step ? ST_RESP : ST_READ;
      ST_RESP:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath registers.
  always_comb begin
    clr_d   = clr_q;
    col_d   = col_q;
    page_d  = page_q;
    xe_d    = xe_q;
    ys_d    = ys_q;
    ye_d    = ye_q;
    type_d  = type_q;
    color_d = color_q;
    pix_d   = pix_q;
    rej_d   = rej_q;
    if (state_q == ST_CLEAR) begin
      clr_d = clr_q + 1'b1;
    end
    if (accept) begin
      col_d   = COL_W'(x_start_i);
      page_d  = PAGE_W'(ROW_W'(y_start_i) >> 3);
      xe_d    = xe_clip;
      ys_d    = ROW_W'(y_start_i);
      ye_d    = ye_clip;
      type_d  = req_type_i;
      color_d = color_i;
      pix_d   = 1'b0;
      rej_d   = reject;
    end
    if (state_q == ST_WRITE) begin
      if (type_q == REQ_READ) begin
        pix_d = mem_rdata_i[ys_q[2:0]];
      end
      if (type_q == REQ_HSPAN) begin
        col_d = col_q + 1'b1;
      end
      if (type_q == REQ_VSPAN) begin
        page_d = page_q + 1'b1;
      end
    end
  end

  // Outputs.
  always_comb begin
    mem_req_o.we    = 1'b0;
    mem_req_o.addr  = addr;
    mem_req_o.wdata = wbyte;
    unique case (state_q)
      ST_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = clr_q;
        mem_req_o.wdata = 8'h00;
      end
      ST_WRITE: mem_req_o.we = (type_q != REQ_READ);
      default:  mem_req_o.we = 1'b0;
    endcase
    busy_o         = (state_q != ST_IDLE);
    result_valid_o = (state_q == ST_RESP);
    pixel_value_o  = pix_q;
    rejected_o     = rej_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q   <= col_d;
    page_q  <= page_d;
    xe_q    <= xe_d;
    ys_q    <= ys_d;
    ye_q    <= ye_d;
    type_q  <= type_d;
    color_q <= color_d;
    pix_q   <= pix_d;
    rej_q   <= rej_d;
  end

endmodule

>>> design/mono_page_framebuffer_draw.sv
// Top level of the monochrome page frame store with pixel and span drawing.
// Instantiates mpfb_seq and mpfb_store. Depends on mpfb_pkg.
`timescale 1ns / 1ps

// A word is taken when start is high while busy is low, and exactly one
// result word follows, shown for one cycle with result_valid_o high; the
// receiver cannot stall it. After reset the store is cleared one byte per
// cycle, so busy stays high until all STORE_DEPTH (1024) bytes are cleared.
// Every byte touched by a set or a span is read and then written on the
// single store port; a pixel read only reads its byte. A rejected or empty
// request touches no byte and goes straight to the result word.
module mono_page_framebuffer_draw
  import mpfb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] req_type_i,
  input  logic [7:0] x_start_i,
  input  logic [7:0] x_end_i,
  input  logic [7:0] y_start_i,
  input  logic [7:0] y_end_i,
  input  logic       color_i,
  output logic       result_valid_o,
  output logic       pixel_value_o,
  output logic       rejected_o
);

  mem_req_t   mem_req;
  logic [7:0] mem_rdata;

  mpfb_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_o         (busy),
    .req_type_i     (req_type_i),
    .x_start_i      (x_start_i),
    .x_end_i        (x_end_i),
    .y_start_i      (y_start_i),
    .y_end_i        (y_end_i),
    .color_i        (color_i),
    .result_valid_o (result_valid_o),
    .pixel_value_o  (pixel_value_o),
    .rejected_o     (rejected_o),
    .mem_req_o      (mem_req),
    .mem_rdata_i    (mem_rdata)
  );

  mpfb_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule

>>> tb/mono_page_framebuffer_draw_tb.sv
// Testbench for mono_page_framebuffer_draw: directed and random pixel and span words,
// checked against a local page store model kept in a small scoreboard class.
// Depends on mpfb_pkg and the mono_page_framebuffer_draw RTL.
`timescale 1ns / 1ps

module mono_page_framebuffer_draw_tb;
  import mpfb_pkg::*;

  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 300;
  localparam int RANDOM_WORDS = 1900;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] x_start;
    logic [7:0] x_end;
    logic [7:0] y_start;
    logic [7:0] y_end;
    logic       color;
  } draw_word_t;

  typedef struct packed {
    logic pixel_value;
    logic rejected;
  } reply_t;

  // Keeps its own copy of the page store and the replies still owed by the block.
  class frame_scoreboard;
    logic [7:0] pages [STORE_DEPTH];
    reply_t     owed [$];
    int         errors;

    function new();
      errors = 0;
      foreach (pages[i]) pages[i] = 8'h00;
    endfunction

    function void paint(int col, int row, logic c);
      int idx;
      idx = (row / PAGE_ROWS) * PANEL_WIDTH + col;
      if (idx < STORE_DEPTH) pages[idx][row % PAGE_ROWS] = c;
    endfunction

    function void note_request(draw_word_t w);
      reply_t r;
      int     last;
      int     col;
      int     row;
      r.pixel_value = 1'b0;
      r.rejected    = 1'b0;
      col = int'(w.x_start);
      row = int'(w.y_start);
      if (col >= PANEL_WIDTH || row >= PANEL_HEIGHT) begin
        r.rejected = 1'b1;
      end else begin
        case (w.kind)
          REQ_SET: begin
            paint(col, row, w.color);
          end
          REQ_READ: begin
            r.pixel_value = pages[(row / PAGE_ROWS) * PANEL_WIDTH + col][row % PAGE_ROWS];
          end
          REQ_HSPAN: begin
            last = (int'(w.x_end) >= PANEL_WIDTH) ? PANEL_WIDTH - 1 : int'(w.x_end);
            for (int i = col; i <= last; i++) paint(i, row, w.color);
          end
          default: begin
            last = (int'(w.y_end) >= PANEL_HEIGHT) ? PANEL_HEIGHT - 1 : int'(w.y_end);
            for (int i = row; i <= last; i++) paint(col, i, w.color);
          end
        endcase
      end
      owed.push_back(r);
    endfunction

    function void check_result(logic pix, logic rej);
      reply_t e;
      if (owed.size() == 0) begin
        $error("result word with nothing outstanding: pixel_value=%0b rejected=%0b", pix, rej);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (pix !== e.pixel_value) begin
        $error("pixel_value mismatch: expected %0b, actual %0b", e.pixel_value, pix);
        errors++;
      end
      if (rej !== e.rejected) begin
        $error("rejected mismatch: expected %0b, actual %0b", e.rejected, rej);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic [1:0] req_type_i;
  logic [7:0] x_start_i;
  logic [7:0] x_end_i;
  logic [7:0] y_start_i;
  logic [7:0] y_end_i;
  logic       color_i;
  logic       result_valid_o;
  logic       pixel_value_o;
  logic       rejected_o;

  frame_scoreboard sb;
  draw_word_t      words [$];
  bit              word_taken;

  mono_page_framebuffer_draw DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .x_start_i      (x_start_i),
    .x_end_i        (x_end_i),
    .y_start_i      (y_start_i),
    .y_end_i        (y_end_i),
    .color_i        (color_i),
    .result_valid_o (result_valid_o),
    .pixel_value_o  (pixel_value_o),
    .rejected_o     (rejected_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic draw_word_t mk(logic [1:0] kind, int xs, int xe, int ys, int ye,
                                    logic c);
    draw_word_t w;
    w.kind    = kind;
    w.x_start = xs[7:0];
    w.x_end   = xe[7:0];
    w.y_start = ys[7:0];
    w.y_end   = ye[7:0];
    w.color   = c;
    return w;
  endfunction

  // One clock edge: note whether the offered word was taken and check any result word.
  task automatic tick();
    @(posedge clk_i);
    word_taken = start && !busy;
    if (result_valid_o) sb.check_result(pixel_value_o, rejected_o);
  endtask

  task automatic drive_words();
    draw_word_t cur;
    int         idx;
    bit         offering;
    bit         calm;
    idx      = 0;
    offering = 1'b0;
    while (idx < words.size() || offering) begin
      tick();
      if (offering && word_taken) begin
        sb.note_request(cur);
        offering = 1'b0;
      end
      if (!offering) begin
        // A long stretch in the middle of the run goes without any idle cycles.
        calm = (idx >= 700 && idx < 1000);
        if (idx < words.size() && (calm || $urandom_range(99) >= 24)) begin
          cur = words[idx];
          idx++;
          req_type_i <= cur.kind;
          x_start_i  <= cur.x_start;
          x_end_i    <= cur.x_end;
          y_start_i  <= cur.y_start;
          y_end_i    <= cur.y_end;
          color_i    <= cur.color;
          offering = 1'b1;
        end
        start <= offering;
      end
    end
  endtask

  // Ends the run when neither a word is taken nor a result appears for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((start && !busy) || result_valid_o) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    draw_word_t w;
    int         pick;
    int         span;
    sb         = new();
    rst_ni     <= 1'b0;
    start      <= 1'b0;
    req_type_i <= REQ_SET;
    x_start_i  <= 8'h00;
    x_end_i    <= 8'h00;
    y_start_i  <= 8'h00;
    y_end_i    <= 8'h00;
    color_i    <= 1'b0;

    // Corners, rejection of each start coordinate, clipping and empty spans.
    words.push_back(mk(REQ_SET,   0, 200, 0, 77, 1'b1));
    words.push_back(mk(REQ_READ,  0, 255, 0, 255, 1'b0));
    words.push_back(mk(REQ_READ,  127, 0, 63, 0, 1'b1));
    words.push_back(mk(REQ_SET,   127, 0, 63, 0, 1'b1));
    words.push_back(mk(REQ_READ,  127, 0, 63, 0, 1'b0));
    words.push_back(mk(REQ_SET,   128, 0, 10, 0, 1'b1));
    words.push_back(mk(REQ_READ,  255, 0, 10, 0, 1'b0));
    words.push_back(mk(REQ_HSPAN, 10, 20, 64, 0, 1'b1));
    words.push_back(mk(REQ_VSPAN, 10, 0, 255, 255, 1'b1));
    words.push_back(mk(REQ_HSPAN, 0, 255, 5, 0, 1'b1));
    words.push_back(mk(REQ_READ,  64, 0, 5, 0, 1'b0));
    words.push_back(mk(REQ_VSPAN, 10, 99, 0, 255, 1'b1));
    words.push_back(mk(REQ_READ,  10, 0, 63, 0, 1'b0));
    words.push_back(mk(REQ_HSPAN, 50, 49, 20, 0, 1'b1));
    words.push_back(mk(REQ_VSPAN, 30, 0, 40, 39, 1'b1));
    words.push_back(mk(REQ_READ,  50, 0, 20, 0, 1'b0));
    words.push_back(mk(REQ_HSPAN, 90, 90, 33, 0, 1'b1));
    words.push_back(mk(REQ_READ,  90, 0, 33, 0, 1'b0));
    words.push_back(mk(REQ_VSPAN, 10, 0, 6, 9, 1'b0));
    words.push_back(mk(REQ_READ,  10, 0, 7, 0, 1'b0));
    words.push_back(mk(REQ_READ,  10, 0, 10, 0, 1'b0));
    words.push_back(mk(REQ_HSPAN, 0, 127, 5, 0, 1'b0));
    words.push_back(mk(REQ_READ,  127, 0, 5, 0, 1'b0));

    // Mostly in-panel words with short spans, plus out-of-panel starts and wild ends.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      pick = $urandom_range(99);
      if (pick < 35)      w.kind = REQ_READ;
      else if (pick < 55) w.kind = REQ_SET;
      else if (pick < 78) w.kind = REQ_HSPAN;
      else                w.kind = REQ_VSPAN;
      if ($urandom_range(99) < 8) w.x_start = 8'($urandom_range(255, PANEL_WIDTH));
      else                        w.x_start = 8'($urandom_range(PANEL_WIDTH - 1, 0));
      if ($urandom_range(99) < 8) w.y_start = 8'($urandom_range(255, PANEL_HEIGHT));
      else                        w.y_start = 8'($urandom_range(PANEL_HEIGHT - 1, 0));
      pick = $urandom_range(99);
      if (pick < 15)      w.x_end = 8'($urandom_range(255, 0));
      else if (pick < 25) w.x_end = w.x_start - 8'($urandom_range(8, 1));
      else begin
        span    = $urandom_range(40, 0);
        w.x_end = w.x_start + 8'(span);
      end
      pick = $urandom_range(99);
      if (pick < 15)      w.y_end = 8'($urandom_range(255, 0));
      else if (pick < 25) w.y_end = w.y_start - 8'($urandom_range(8, 1));
      else begin
        span    = $urandom_range(20, 0);
        w.y_end = w.y_start + 8'(span);
      end
      w.color = 1'($urandom_range(1, 0));
      words.push_back(w);
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    drive_words();
    while (sb.owed.size() != 0) tick();
    repeat (DRAIN_CYCLES) tick();

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> mono_page_framebuffer_draw.f
design/mpfb_pkg.sv
design/mpfb_store.sv
design/mpfb_seq.sv
design/mono_page_framebuffer_draw.sv
tb/mono_page_framebuffer_draw_tb.sv
